// ----- rtl/sll_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sll_pkg
// Shared constants and types for the array-backed linked list insert block.
// ----------------------------------------------------------------------------
package sll_pkg;

  // Slot store geometry
  localparam int unsigned DEPTH     = 1024;
  localparam int unsigned AW        = $clog2(DEPTH);
  localparam int unsigned DW        = 32;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned LEN_W     = 10;

  // Slot DEPTH-1 heads the data chain; at most DEPTH-2 elements fit
  localparam logic [AW-1:0]    HEAD_SLOT = AW'(DEPTH - 1);
  localparam logic [LEN_W-1:0] MAX_COUNT = LEN_W'(DEPTH - 2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_SPLICE
  } ctrl_state_e;

  // One port of the link memory: one write and one read per cycle
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } link_req_t;

  // Result of one transaction
  typedef struct packed {
    logic             ok;
    logic [AW-1:0]    slot;
    logic [LEN_W-1:0] length;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/static_linked_list_insert.sv -----
`default_nettype none
// Timing: a rejected request answers in the cycle after acceptance; an insert at
//   position p walks the data chain in ST_WALK (one link read per hop), then
//   splices in ST_SPLICE and answers from the output register. Throughput: one
//   transaction at a time, the walk paced by the single link memory read port.
// Reset: list empty, free slots handed out from slot 1; no clearing pass.
// ----------------------------------------------------------------------------
// static_linked_list_insert
// Array-backed linked list, slots handed out in order; inserts a value at a position.
// ----------------------------------------------------------------------------
module static_linked_list_insert (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic [sll_pkg::POS_W-1:0]     position_i,
  input  wire logic signed [sll_pkg::DW-1:0] value_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic                          ok_o,
  output      logic [sll_pkg::AW-1:0]        slot_o,
  output      logic [sll_pkg::LEN_W-1:0]     length_o
);
  import sll_pkg::*;

  link_req_t        link_req;
  logic [AW-1:0]    link_rdata;
  logic             data_we;
  logic [AW-1:0]    data_waddr;
  logic [DW-1:0]    data_wdata;
  logic             res_load;
  result_t          res;
  logic             out_valid_q, out_valid_d;
  result_t          out_q;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  sll_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .position_i   (position_i),
    .value_i      (value_i),
    .out_free_i   (out_free),
    .link_rdata_i (link_rdata),
    .link_req_o   (link_req),
    .data_we_o    (data_we),
    .data_waddr_o (data_waddr),
    .data_wdata_o (data_wdata),
    .res_load_o   (res_load),
    .res_o        (res)
  );

  // Link memory: next-slot links of the data chain
  sll_ram #(
    .WIDTH (AW),
    .DEPTH (DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_req.we),
    .waddr_i (link_req.waddr),
    .wdata_i (link_req.wdata),
    .re_i    (link_req.re),
    .raddr_i (link_req.raddr),
    .rdata_o (link_rdata)
  );

  // Data memory: written on insert, never read back here
  sll_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (data_waddr),
    .wdata_i (data_wdata),
    .re_i    (1'b0),
    .raddr_i ('0),
    .rdata_o ()
  );

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = out_q.ok;
  assign slot_o      = out_q.slot;
  assign length_o    = out_q.length;

endmodule
`default_nettype wire

// ----- rtl/sll_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sll_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sll_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sll_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sll_ctrl
// Insert sequencer: checks the request, allocates the next free slot, walks
// the data chain through the link memory and splices the new node in.
// ----------------------------------------------------------------------------
module sll_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic [sll_pkg::POS_W-1:0]   position_i,
  input  wire logic signed [sll_pkg::DW-1:0] value_i,
  input  wire logic                        out_free_i,
  input  wire logic [sll_pkg::AW-1:0]      link_rdata_i,
  output      sll_pkg::link_req_t          link_req_o,
  output      logic                        data_we_o,
  output      logic [sll_pkg::AW-1:0]      data_waddr_o,
  output      logic [sll_pkg::DW-1:0]      data_wdata_o,
  output      logic                        res_load_o,
  output      sll_pkg::result_t            res_o
);
  import sll_pkg::*;

  ctrl_state_e      state_q, state_d;
  logic [LEN_W-1:0] count_q, count_d;
  logic [POS_W-1:0] left_q, left_d;
  logic [AW-1:0]    cur_q, cur_d;
  logic [AW-1:0]    fresh_q, fresh_d;
  logic             empty_q, empty_d;

  logic accept;
  logic good;

  // Request check: position in 1..length+1 and a free slot left
  assign accept = in_valid_i && (state_q == ST_IDLE) && out_free_i;
  assign good   = (position_i != '0)
               && ({1'b0, position_i} <= ({1'b0, count_q} + 11'd1))
               && (count_q != MAX_COUNT);
  assign in_stall_o = !((state_q == ST_IDLE) && out_free_i);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && good) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (left_q == '0) begin
          state_d = ST_SPLICE;
        end
      end
      ST_SPLICE: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs: memory requests and result
  always_comb begin
    link_req_o   = '0;
    data_we_o    = 1'b0;
    data_waddr_o = fresh_d;
    data_wdata_o = value_i;
    res_load_o   = 1'b0;
    res_o        = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && good) begin
          // free slots go out in order, so the next one is count+1
          data_we_o        = 1'b1;
          link_req_o.re    = 1'b1;
          link_req_o.raddr = HEAD_SLOT;
        end else if (accept) begin
          res_load_o    = 1'b1;
          res_o.length  = count_q;
        end
      end
      ST_WALK: begin
        if (left_q == '0) begin
          // successor of prev becomes successor of the new node
          link_req_o.we    = 1'b1;
          link_req_o.waddr = fresh_q;
          link_req_o.wdata = empty_q ? '0 : link_rdata_i;
        end else begin
          link_req_o.re    = 1'b1;
          link_req_o.raddr = link_rdata_i;
        end
      end
      ST_SPLICE: begin
        link_req_o.we    = 1'b1;
        link_req_o.waddr = cur_q;
        link_req_o.wdata = fresh_q;
        res_load_o       = 1'b1;
        res_o.ok         = 1'b1;
        res_o.slot       = fresh_q;
        res_o.length     = count_q + LEN_W'(1);
      end
      default: ;
    endcase
  end

  // Walk datapath
  always_comb begin
    count_d = count_q;
    left_d  = left_q;
    cur_d   = cur_q;
    fresh_d = fresh_q;
    empty_d = empty_q;
    if (accept && good) begin
      fresh_d = AW'(count_q) + AW'(1);
      left_d  = position_i - POS_W'(1);
      cur_d   = HEAD_SLOT;
      empty_d = (count_q == '0);
    end else if (state_q == ST_WALK && left_q != '0) begin
      cur_d  = link_rdata_i;
      left_d = left_q - POS_W'(1);
    end else if (state_q == ST_SPLICE) begin
      count_d = count_q + LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q  <= left_d;
    cur_q   <= cur_d;
    fresh_q <= fresh_d;
    empty_q <= empty_d;
  end

endmodule
`default_nettype wire
